/* hdl/mfrw_pkg.sv */
// shared types, widths and constants of the mecanum frame rotate and wheel mix unit
`default_nettype none

package mfrw_pkg;

    // cordic datapath widths (q30 x/y, q20 degrees z)
    localparam int XW        = 32;
    localparam int ZW        = 29;
    localparam int COR_FRAC  = 30;
    localparam int AW        = 19;
    localparam int COR_Z_SHIFT = 12;
    localparam int TABLE_LEN = 24;

    // item field widths
    localparam int VW  = 16;
    localparam int ANW = 18;
    localparam int HW  = 12;
    localparam int RPW = 24;
    localparam int WW  = 16;

    // mix and scaling widths
    localparam int MIX_GUARD       = 4;
    localparam int MIX_SPEED_SHIFT = 10;
    localparam int WPW       = 28;
    localparam int RW        = 33;
    localparam int RPM_SPLIT = 12;
    localparam int PLW       = RW + RPM_SPLIT + 1;
    localparam int PRW       = 58;
    localparam int RPM_SHIFT = 32;
    localparam int QW        = PRW - RPM_SHIFT;

    // configuration register indexes
    localparam int CIW = 8;
    localparam logic [CIW-1:0] CFG_HALF_LENGTH_SUM = 8'd0;
    localparam logic [CIW-1:0] CFG_RPM_PER_SPEED   = 8'd1;

    localparam logic [HW-1:0]  HALF_LENGTH_SUM_RST = 12'd512;
    localparam logic [RPW-1:0] RPM_PER_SPEED_RST   = 24'd614400;

    // angles in q8 degrees
    localparam logic signed [AW-1:0] ANG_HALF    = 19'sd46080;
    localparam logic signed [AW-1:0] ANG_FULL    = 19'sd92160;
    localparam logic signed [AW-1:0] ANG_QUARTER = 19'sd23040;

    // cordic gain 0.60725293 in q30
    localparam logic signed [XW-1:0] COR_GAIN = 32'sd652032874;

    localparam logic signed [WW-1:0] WHEEL_MAX = 16'sh7fff;
    localparam logic signed [WW-1:0] WHEEL_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic signed [VW-1:0] vx;
        logic signed [VW-1:0] vy;
        logic signed [VW-1:0] vw;
        logic                 neg;
    } t_rot;

    typedef struct packed {
        logic signed [WW-1:0] fl;
        logic signed [WW-1:0] fr;
        logic signed [WW-1:0] rl;
        logic signed [WW-1:0] rr;
        logic                 clipped;
    } t_wheels;

    // atan(2^-i) in degrees, q20
    function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:  v = 29'sd47185920;
            5'd1:  v = 29'sd27855475;
            5'd2:  v = 29'sd14718068;
            5'd3:  v = 29'sd7471121;
            5'd4:  v = 29'sd3750058;
            5'd5:  v = 29'sd1876857;
            5'd6:  v = 29'sd938658;
            5'd7:  v = 29'sd469357;
            5'd8:  v = 29'sd234682;
            5'd9:  v = 29'sd117342;
            5'd10: v = 29'sd58671;
            5'd11: v = 29'sd29335;
            5'd12: v = 29'sd14668;
            5'd13: v = 29'sd7334;
            5'd14: v = 29'sd3667;
            5'd15: v = 29'sd1833;
            5'd16: v = 29'sd917;
            5'd17: v = 29'sd458;
            5'd18: v = 29'sd229;
            5'd19: v = 29'sd115;
            5'd20: v = 29'sd57;
            5'd21: v = 29'sd29;
            5'd22: v = 29'sd14;
            5'd23: v = 29'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* hdl/mfrw_cordic_cell.sv */
// one registered cordic rotation cell with its own valid/ready stage
`default_nettype none

module mfrw_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  mfrw_pkg::t_rot    i_data,
    output logic              o_valid,
    input  wire               i_ready,
    output mfrw_pkg::t_rot    o_data
);

    localparam logic signed [mfrw_pkg::ZW-1:0] ATAN = mfrw_pkg::atan_deg(5'(STAGE));

    logic                              r_valid;
    mfrw_pkg::t_rot                    r_data;
    mfrw_pkg::t_rot                    n_data;
    logic signed [mfrw_pkg::XW-1:0]    w_dx;
    logic signed [mfrw_pkg::XW-1:0]    w_dy;

    assign o_ready = ~r_valid | i_ready;

    always_comb begin
        w_dx   = $signed(i_data.y) >>> STAGE;
        w_dy   = $signed(i_data.x) >>> STAGE;
        n_data = i_data;
        if (!i_data.z[mfrw_pkg::ZW-1]) begin
            n_data.x = i_data.x - w_dx;
            n_data.y = i_data.y + w_dy;
            n_data.z = i_data.z - ATAN;
        end else begin
            n_data.x = i_data.x + w_dx;
            n_data.y = i_data.y - w_dy;
            n_data.z = i_data.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

/* hdl/mfrw_mix.sv */
// rounding, frame rotation, wheel mix, rpm scaling and saturation pipeline
`default_nettype none

module mfrw_mix #(
    parameter int TRIG_FRACTION_BITS = 14
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  mfrw_pkg::t_rot               i_data,
    input  wire  [mfrw_pkg::HW-1:0]      i_half_length_sum,
    input  wire  [mfrw_pkg::RPW-1:0]     i_rpm_per_speed,
    output logic                         o_valid,
    input  wire                          i_ready,
    output mfrw_pkg::t_wheels            o_data
);

    localparam int F   = TRIG_FRACTION_BITS;
    localparam int TW  = F + 2;
    localparam int PW  = F + 18;
    localparam int SW  = F + 19;
    localparam int MW  = F + 30;
    localparam int SHR = mfrw_pkg::COR_FRAC - F;
    localparam int G   = F - mfrw_pkg::MIX_GUARD;
    localparam int NST = 10;
    localparam int XW  = mfrw_pkg::XW;
    localparam int VW  = mfrw_pkg::VW;
    localparam int RW  = mfrw_pkg::RW;
    localparam int PLW = mfrw_pkg::PLW;
    localparam int PRW = mfrw_pkg::PRW;
    localparam int QW  = mfrw_pkg::QW;
    localparam int WW  = mfrw_pkg::WW;
    localparam int WPW = mfrw_pkg::WPW;
    localparam int RS  = mfrw_pkg::RPM_SPLIT;
    localparam logic signed [XW-1:0] RND = XW'(64'sd1 <<< (SHR - 1));

    logic [NST-1:0] r_v;
    logic [NST:0]   w_rdy;

    assign w_rdy[NST] = i_ready;
    genvar k;
    generate
        for (k = 0; k < NST; k++) begin : g_rdy
            assign w_rdy[k] = ~r_v[k] | w_rdy[k+1];
        end
    endgenerate

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NST; s++) begin
                if (w_rdy[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // stage 0: round cos/sin to q(F) and undo the half-turn fold
    logic signed [XW-1:0] w_xs, w_ys;
    logic signed [TW-1:0] w_c, w_s;
    logic signed [TW-1:0] r_c, r_s;
    logic signed [VW-1:0] r_vx, r_vy, r_vw;

    always_comb begin
        w_xs = (i_data.x + RND) >>> SHR;
        w_ys = (i_data.y + RND) >>> SHR;
        w_c  = i_data.neg ? -w_xs[TW-1:0] : w_xs[TW-1:0];
        w_s  = i_data.neg ? -w_ys[TW-1:0] : w_ys[TW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_c  <= w_c;
            r_s  <= w_s;
            r_vx <= i_data.vx;
            r_vy <= i_data.vy;
            r_vw <= i_data.vw;
        end
    end

    // stage 1: rotation products and yaw lever product
    logic signed [PW-1:0]  r_pxc, r_pys, r_pxs, r_pyc;
    logic signed [WPW-1:0] r_pw;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_pxc <= PW'(r_vx) * PW'(r_c);
            r_pys <= PW'(r_vy) * PW'(r_s);
            r_pxs <= PW'(r_vx) * PW'(r_s);
            r_pyc <= PW'(r_vy) * PW'(r_c);
            r_pw  <= WPW'(r_vw) * WPW'($signed({1'b0, i_half_length_sum}));
        end
    end

    // stage 2: chassis frame speeds
    logic signed [SW-1:0]  r_rx, r_ry;
    logic signed [WPW-1:0] r_w2;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_rx <= SW'(r_pxc) - SW'(r_pys);
            r_ry <= SW'(r_pxs) + SW'(r_pyc);
            r_w2 <= r_pw;
        end
    end

    // stage 3: diagonal sums
    logic signed [SW-1:0]  r_a, r_b;
    logic signed [WPW-1:0] r_w3;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_a  <= r_rx + r_ry;
            r_b  <= r_rx - r_ry;
            r_w3 <= r_w2;
        end
    end

    // stage 4: wheel mix at 2^-(20+F) m/s
    logic signed [MW-1:0] w_ma, w_mb, w_mw;
    logic signed [MW-1:0] r_m [4];

    always_comb begin
        w_ma = MW'(r_a) <<< mfrw_pkg::MIX_SPEED_SHIFT;
        w_mb = MW'(r_b) <<< mfrw_pkg::MIX_SPEED_SHIFT;
        w_mw = MW'(r_w3) <<< F;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_m[0] <= -w_ma - w_mw;
            r_m[1] <= w_mb - w_mw;
            r_m[2] <= w_ma - w_mw;
            r_m[3] <= -w_mb - w_mw;
        end
    end

    // stage 5: truncate toward zero to 24 fraction bits
    logic signed [MW-1:0] w_mt [4];
    logic signed [RW-1:0] r_r [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_mt[i] = (r_m[i] + $signed({{(MW-G){1'b0}}, {G{r_m[i][MW-1]}}})) >>> G;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            for (int i = 0; i < 4; i++) begin
                r_r[i] <= w_mt[i][RW-1:0];
            end
        end
    end

    // stage 6: rpm scaling split into two narrow partial products
    logic signed [PLW-1:0] r_plo [4];
    logic signed [PLW-1:0] r_phi [4];

    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            for (int i = 0; i < 4; i++) begin
                r_plo[i] <= PLW'(r_r[i]) * PLW'($signed({1'b0, i_rpm_per_speed[RS-1:0]}));
                r_phi[i] <= PLW'(r_r[i]) *
                            PLW'($signed({1'b0, i_rpm_per_speed[mfrw_pkg::RPW-1:RS]}));
            end
        end
    end

    // stage 7: recombine partial products
    logic signed [PRW-1:0] r_prod [4];

    always_ff @(posedge i_clk) begin
        if (w_rdy[7]) begin
            for (int i = 0; i < 4; i++) begin
                r_prod[i] <= (PRW'(r_phi[i]) <<< RS) + PRW'(r_plo[i]);
            end
        end
    end

    // stage 8: truncate toward zero to whole rpm
    logic signed [PRW-1:0] w_pq [4];
    logic signed [QW-1:0]  r_q [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_pq[i] = (r_prod[i] + $signed({{QW{1'b0}},
                      {mfrw_pkg::RPM_SHIFT{r_prod[i][PRW-1]}}})) >>> mfrw_pkg::RPM_SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[8]) begin
            for (int i = 0; i < 4; i++) begin
                r_q[i] <= w_pq[i][QW-1:0];
            end
        end
    end

    // stage 9: saturate to 16 bits
    logic signed [WW-1:0] w_sat [4];
    logic [3:0]           w_clip;
    logic [QW-WW:0]       w_hi [4];
    mfrw_pkg::t_wheels    r_out;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_hi[i]   = r_q[i][QW-1:WW-1];
            w_clip[i] = (w_hi[i] != '0) && (w_hi[i] != '1);
            if (w_clip[i]) begin
                w_sat[i] = r_q[i][QW-1] ? mfrw_pkg::WHEEL_MIN : mfrw_pkg::WHEEL_MAX;
            end else begin
                w_sat[i] = r_q[i][WW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[9]) begin
            r_out.fl      <= w_sat[0];
            r_out.fr      <= w_sat[1];
            r_out.rl      <= w_sat[2];
            r_out.rr      <= w_sat[3];
            r_out.clipped <= |w_clip;
        end
    end

    assign o_data = r_out;

endmodule

`default_nettype wire

/* hdl/mecanum_frame_rotate_wheel_mix_unit.sv */
// top level: angle fold, chain of cordic cells and the wheel mix pipeline
`default_nettype none

// Takes a gimbal-frame velocity command (speed_x, speed_y, yaw_rate) and the
// gimbal-to-chassis angle, rotates the command into the chassis frame with a
// chain of ROTATION_STAGES cordic cells, and mixes it into four mecanum wheel
// rpm targets, saturated to 16 bits with a clipped flag in tuser. One item is
// accepted every cycle while the output side keeps tready high; an item passes
// through the input register, the cordic cells and the mix stages. Every stage
// carries its own valid bit, so bubbles are squeezed out while the output
// stalls. The configuration registers are taken from the cfg channel (always
// ready) and must only change while no item is in flight.
module mecanum_frame_rotate_wheel_mix_unit #(
    parameter int ROTATION_STAGES    = 16,
    parameter int TRIG_FRACTION_BITS = 14
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // speed_x [15:0], speed_y [31:16], yaw_rate [47:32], frame_angle [65:48], zero pad
    input  wire  [71:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // wheel_front_left [15:0], wheel_front_right [31:16],
    // wheel_rear_left [47:32], wheel_rear_right [63:48]
    output logic [63:0] o_m_axis_tdata,
    // clipped [0]
    output logic        o_m_axis_tuser,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [7:0]  i_cfg_index,
    input  wire  [23:0] i_cfg_data
);

    localparam int AW = mfrw_pkg::AW;
    localparam int ZW = mfrw_pkg::ZW;
    localparam int N  = ROTATION_STAGES;

    // configuration registers
    logic [mfrw_pkg::HW-1:0]  r_half_length_sum;
    logic [mfrw_pkg::RPW-1:0] r_rpm_per_speed;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_length_sum <= mfrw_pkg::HALF_LENGTH_SUM_RST;
            r_rpm_per_speed   <= mfrw_pkg::RPM_PER_SPEED_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mfrw_pkg::CFG_HALF_LENGTH_SUM: r_half_length_sum <= i_cfg_data[mfrw_pkg::HW-1:0];
                mfrw_pkg::CFG_RPM_PER_SPEED:   r_rpm_per_speed   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // angle fold into [-90, 90] degrees, remembering a half-turn
    logic signed [AW-1:0] w_ang0, w_ang1, w_ang2;
    logic                 w_neg;
    mfrw_pkg::t_rot       n_s0_data;

    always_comb begin
        w_ang0 = AW'($signed(i_s_axis_tdata[65:48]));
        w_ang1 = w_ang0;
        if (w_ang1 >= mfrw_pkg::ANG_HALF) begin
            w_ang1 = w_ang1 - mfrw_pkg::ANG_FULL;
        end
        if (w_ang1 < -mfrw_pkg::ANG_HALF) begin
            w_ang1 = w_ang1 + mfrw_pkg::ANG_FULL;
        end
        w_ang2 = w_ang1;
        w_neg  = 1'b0;
        if (w_ang1 > mfrw_pkg::ANG_QUARTER) begin
            w_ang2 = w_ang1 - mfrw_pkg::ANG_HALF;
            w_neg  = 1'b1;
        end else if (w_ang1 < -mfrw_pkg::ANG_QUARTER) begin
            w_ang2 = w_ang1 + mfrw_pkg::ANG_HALF;
            w_neg  = 1'b1;
        end
        n_s0_data.x   = mfrw_pkg::COR_GAIN;
        n_s0_data.y   = '0;
        n_s0_data.z   = ZW'(w_ang2) <<< mfrw_pkg::COR_Z_SHIFT;
        n_s0_data.vx  = i_s_axis_tdata[15:0];
        n_s0_data.vy  = i_s_axis_tdata[31:16];
        n_s0_data.vw  = i_s_axis_tdata[47:32];
        n_s0_data.neg = w_neg;
    end

    logic           r_s0_valid;
    mfrw_pkg::t_rot r_s0_data;
    logic [N:0]     w_valid;
    logic [N:0]     w_ready;
    mfrw_pkg::t_rot w_data [N+1];

    assign o_s_axis_tready = ~r_s0_valid | w_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s0_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_s0_data <= n_s0_data;
        end
    end

    assign w_valid[0] = r_s0_valid;
    assign w_data[0]  = r_s0_data;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            mfrw_cordic_cell #(
                .STAGE (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[g]),
                .o_ready (w_ready[g]),
                .i_data  (w_data[g]),
                .o_valid (w_valid[g+1]),
                .i_ready (w_ready[g+1]),
                .o_data  (w_data[g+1])
            );
        end
    endgenerate

    mfrw_pkg::t_wheels w_out;

    mfrw_mix #(
        .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
    ) u_mix (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_valid[N]),
        .o_ready           (w_ready[N]),
        .i_data            (w_data[N]),
        .i_half_length_sum (r_half_length_sum),
        .i_rpm_per_speed   (r_rpm_per_speed),
        .o_valid           (o_m_axis_tvalid),
        .i_ready           (i_m_axis_tready),
        .o_data            (w_out)
    );

    assign o_m_axis_tdata = {w_out.rr, w_out.rl, w_out.fr, w_out.fl};
    assign o_m_axis_tuser = w_out.clipped;

    // an empty output register means every stage can move, so input is taken
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with an empty output register");

    // a clipped item must carry at least one wheel at a rail
    a_clip_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
            (w_out.fl == mfrw_pkg::WHEEL_MAX || w_out.fl == mfrw_pkg::WHEEL_MIN ||
             w_out.fr == mfrw_pkg::WHEEL_MAX || w_out.fr == mfrw_pkg::WHEEL_MIN ||
             w_out.rl == mfrw_pkg::WHEEL_MAX || w_out.rl == mfrw_pkg::WHEEL_MIN ||
             w_out.rr == mfrw_pkg::WHEEL_MAX || w_out.rr == mfrw_pkg::WHEEL_MIN))
        else $error("clipped set with no wheel at a rail");

    // zero rpm scale forces all wheels to zero without clipping
    a_zero_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_rpm_per_speed == '0) |->
            (o_m_axis_tdata == '0 && !o_m_axis_tuser))
        else $error("nonzero wheel item with zero rpm scale");

endmodule

`default_nettype wire
